@@ rtl/assert_macros.svh @@
// Shared assertion macros for the period meter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define ECPM_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Checks that a consequent follows an antecedent in the cycle after it.
`define ECPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ecpm_pkg.sv @@
package ecpm_pkg;

    // Opcodes carried on the input tuser.
    localparam logic OP_EVENT = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Level codes stored with each measurement.
    localparam logic [1:0] LVL_MARK_SPACE = 2'd0;
    localparam logic [1:0] LVL_SPACE_MARK = 2'd1;
    localparam logic [1:0] LVL_MARK       = 2'd2;
    localparam logic [1:0] LVL_SPACE      = 2'd3;

    // Register indexes on the configuration port (byte address / 4).
    localparam logic [1:0] REG_ACT_ON_RISING   = 2'd0;
    localparam logic [1:0] REG_ACT_ON_FALLING  = 2'd1;
    localparam logic [1:0] REG_DIFFERENCE_MODE = 2'd2;

    // A capture taken above this value in an overflow event predates the wrap.
    localparam logic [15:0] LATE_CAPTURE_LIMIT = 16'hE000;
    localparam logic [31:0] EMPTY_VALUE        = 32'hFFFF_FFFF;

    // One ring entry holds a level code above a 32-bit measurement.
    localparam int ENTRY_W = 34;

    typedef struct packed {
        logic act_on_rising;
        logic act_on_falling;
        logic difference_mode;
    } cfg_t;

    typedef struct packed {
        logic        push;
        logic [1:0]  level;
        logic [31:0] value;
    } meas_t;

endpackage

@@ rtl/edge_capture_period_meter_unit.sv @@
// Input-capture period meter.
// The input stream carries one beat per timer event or read request:
// s_tuser is the opcode (0 event, 1 read); s_tdata holds overflowed,
// captured and the 16-bit capture value. Event beats extend the capture
// to a 32-bit timestamp and push nonzero periods, with a level code,
// into a ring of RING_DEPTH slots (one slot always kept free).
// Read beats pop the oldest entry, or return all ones when the ring is empty.
// Every beat gives exactly one output beat with value, level and fill count.
// Each beat passes through the input register and then the output register:
// the accepting edge loads the input register, and the timestamp subtract and
// ring update go into the output register when the beat advances. It takes
// one beat per cycle while the output is not stalled, a rate set by the
// single ring write port and the registered ring read issued at acceptance.
// When m_tready is low the output beat holds, one more beat waits in the
// input register, and s_tready drops only when both are full.
// Reset empties the ring, clears the timestamp state and loads the
// registers to act_on_rising = 1, the others 0. No clearing pass is needed.
// Registers are written over APB at byte addresses 0, 4 and 8.
`include "assert_macros.svh"

module edge_capture_period_meter_unit #(
    parameter int RING_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // [0] overflowed, [1] captured, [17:2] capture_value
    input  logic        s_tuser,  // [0] opcode

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata   // [31:0] read_value, [33:32] read_level, [37:34] fill_count
);

    import ecpm_pkg::*;

    localparam int IW = $clog2(RING_DEPTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(RING_DEPTH - 1);
    localparam logic [IW:0]   DEPTH_W  = (IW + 1)'(RING_DEPTH);

    function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] idx);
        logic [IW-1:0] n;
        n = (idx == LAST_IDX) ? '0 : idx + IW'(1);
        return n;
    endfunction

    // Configuration registers.
    cfg_t cfg_reg;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.act_on_rising   <= 1'b1;
            cfg_reg.act_on_falling  <= 1'b0;
            cfg_reg.difference_mode <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_ACT_ON_RISING:   cfg_reg.act_on_rising   <= pwdata[0];
                REG_ACT_ON_FALLING:  cfg_reg.act_on_falling  <= pwdata[0];
                REG_DIFFERENCE_MODE: cfg_reg.difference_mode <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_ACT_ON_RISING:   prdata = {31'd0, cfg_reg.act_on_rising};
            REG_ACT_ON_FALLING:  prdata = {31'd0, cfg_reg.act_on_falling};
            REG_DIFFERENCE_MODE: prdata = {31'd0, cfg_reg.difference_mode};
            default:             prdata = 32'd0;
        endcase
    end

    // Input register stage.
    logic        in_valid_reg;
    logic        in_op_reg;
    logic        in_ovf_reg;
    logic        in_cap_reg;
    logic [15:0] in_value_reg;
    logic        out_valid_reg;

    logic adv, s_acc, proc, is_read, ring_empty, pop, ev_en;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || adv;
    assign s_acc    = s_tvalid && s_tready;
    assign proc     = in_valid_reg && adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            in_op_reg    <= s_tuser;
            in_ovf_reg   <= s_tdata[0];
            in_cap_reg   <= s_tdata[1];
            in_value_reg <= s_tdata[17:2];
        end
    end

    // Timestamp extension and measurement.
    meas_t meas;

    assign is_read = (in_op_reg == OP_READ);
    assign ev_en   = proc && !is_read;

    ecpm_capture u_capture (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .step_en       (ev_en),
        .overflowed    (in_ovf_reg),
        .captured      (in_cap_reg),
        .capture_value (in_value_reg),
        .meas          (meas)
    );

    // Ring indexes; a push that finds the ring full is dropped.
    logic [IW-1:0] wr_idx_reg, wr_idx_next;
    logic [IW-1:0] rd_idx_reg, rd_idx_next;
    logic [IW-1:0] ring_waddr, ring_raddr;
    logic          ring_we;
    logic [ENTRY_W-1:0] ring_wdata, ring_rdata, entry;

    assign ring_empty  = (wr_idx_reg == rd_idx_reg);
    assign pop         = proc && is_read && !ring_empty;
    assign ring_waddr  = next_slot(wr_idx_reg);
    assign ring_we     = ev_en && meas.push && (ring_waddr != rd_idx_reg);
    assign ring_wdata  = {meas.level, meas.value};
    assign wr_idx_next = ring_we ? ring_waddr : wr_idx_reg;
    assign rd_idx_next = pop ? next_slot(rd_idx_reg) : rd_idx_reg;
    // The accepted beat reads the slot it would pop, given the beat ahead of it.
    assign ring_raddr  = next_slot(rd_idx_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
        end else begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

    ecpm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (aclk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .re    (s_acc),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    // Forward an entry written in the same cycle as the read was issued.
    logic               byp_hit_reg;
    logic [ENTRY_W-1:0] byp_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_hit_reg <= 1'b0;
        end else if (s_acc) begin
            byp_hit_reg <= ring_we && (ring_waddr == ring_raddr);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            byp_data_reg <= ring_wdata;
        end
    end

    assign entry = byp_hit_reg ? byp_data_reg : ring_rdata;

    // Result fields.
    logic [1:0]    held_level_reg, held_level_next;
    logic [31:0]   value_next;
    logic [IW:0]   fill_next;
    logic [IW+4:0] fill_wide;

    always_comb begin
        held_level_next = pop ? entry[ENTRY_W-1:32] : held_level_reg;
        if (!is_read) begin
            value_next = 32'd0;
        end else if (ring_empty) begin
            value_next = EMPTY_VALUE;
        end else begin
            value_next = entry[31:0];
        end
        if (wr_idx_next >= rd_idx_next) begin
            fill_next = {1'b0, wr_idx_next} - {1'b0, rd_idx_next};
        end else begin
            fill_next = DEPTH_W + {1'b0, wr_idx_next} - {1'b0, rd_idx_next};
        end
        fill_wide = {4'd0, fill_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_level_reg <= LVL_MARK_SPACE;
        end else if (proc) begin
            held_level_reg <= held_level_next;
        end
    end

    // Output register.
    logic [31:0] out_value_reg;
    logic [1:0]  out_level_reg;
    logic [3:0]  out_fill_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc) begin
            out_value_reg <= value_next;
            out_level_reg <= held_level_next;
            out_fill_reg  <= fill_wide[3:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'd0, out_fill_reg, out_level_reg, out_value_reg};

    // Checks on the ring and the stage control.
    logic [IW:0] fill_now;
    assign fill_now = (wr_idx_reg >= rd_idx_reg)
                    ? {1'b0, wr_idx_reg} - {1'b0, rd_idx_reg}
                    : DEPTH_W + {1'b0, wr_idx_reg} - {1'b0, rd_idx_reg};

    `ECPM_ASSERT_ALWAYS(a_fill_bound, aclk, aresetn, fill_now < DEPTH_W,
        "ring holds too many entries")
    `ECPM_ASSERT_ALWAYS(a_no_overwrite, aclk, aresetn, !ring_we || (ring_waddr != rd_idx_reg),
        "push overwrote the read slot")
    `ECPM_ASSERT_NEXT(a_pop_moves, aclk, aresetn, pop, rd_idx_reg != $past(rd_idx_reg),
        "pop did not advance the read index")
    `ECPM_ASSERT_ALWAYS(a_ready_when_drained, aclk, aresetn, out_valid_reg || s_tready,
        "input stalled with an empty output register")

endmodule

@@ rtl/ecpm_ram.sv @@
module ecpm_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single write port.
    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read; the data holds while re is low.
    always_ff @(posedge clk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/ecpm_capture.sv @@
module ecpm_capture (
    input  logic                aclk,
    input  logic                aresetn,
    input  ecpm_pkg::cfg_t      cfg,
    input  logic                step_en,
    input  logic                overflowed,
    input  logic                captured,
    input  logic [15:0]         capture_value,
    output ecpm_pkg::meas_t     meas
);

    import ecpm_pkg::*;

    logic [15:0] upper_count_reg, upper_count_next;
    logic [31:0] last_rise_time_reg, last_rise_time_next;
    logic [31:0] last_fall_time_reg, last_fall_time_next;
    logic        expect_falling_reg, expect_falling_next;

    logic [15:0] stamp_upper;
    logic [31:0] stamp;
    logic [31:0] ref_time;
    logic        is_rising;
    logic        act;

    // Overflow count, and the upper half that belongs to this capture.
    always_comb begin
        upper_count_next = overflowed ? upper_count_reg + 16'd1 : upper_count_reg;
        if (overflowed && (capture_value > LATE_CAPTURE_LIMIT)) begin
            stamp_upper = upper_count_reg;
        end else begin
            stamp_upper = upper_count_next;
        end
        stamp = {stamp_upper, capture_value};
    end

    // Edge kind alternates; the first capture after reset is rising.
    assign is_rising = !expect_falling_reg;

    // Pick the reference edge and the level code, then one subtract.
    always_comb begin
        last_rise_time_next = last_rise_time_reg;
        last_fall_time_next = last_fall_time_reg;
        expect_falling_next = expect_falling_reg;
        if (is_rising) begin
            act        = cfg.act_on_rising;
            ref_time   = cfg.difference_mode ? last_fall_time_reg : last_rise_time_reg;
            meas.level = cfg.difference_mode ? LVL_SPACE : LVL_MARK_SPACE;
        end else begin
            act        = cfg.act_on_falling;
            ref_time   = cfg.difference_mode ? last_rise_time_reg : last_fall_time_reg;
            meas.level = cfg.difference_mode ? LVL_MARK : LVL_SPACE_MARK;
        end
        meas.value = stamp - ref_time;
        meas.push  = captured && act && (meas.value != 32'd0);
        if (captured) begin
            expect_falling_next = !expect_falling_reg;
            if (is_rising) begin
                last_rise_time_next = stamp;
            end else begin
                last_fall_time_next = stamp;
            end
        end
    end

    // Timestamp state advances once per processed event beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upper_count_reg    <= '0;
            last_rise_time_reg <= '0;
            last_fall_time_reg <= '0;
            expect_falling_reg <= 1'b0;
        end else if (step_en) begin
            upper_count_reg    <= upper_count_next;
            last_rise_time_reg <= last_rise_time_next;
            last_fall_time_reg <= last_fall_time_next;
            expect_falling_reg <= expect_falling_next;
        end
    end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import ecpm_pkg::*;

    localparam int RING_SLOTS = 16;
    localparam int STALL_LIMIT = 1000;

    // One expected output beat.
    typedef struct {
        logic [31:0] value;
        logic [1:0]  level;
        logic [3:0]  fill;
    } meter_result_t;

    // Tracks the meter state and holds the results still owed by the block.
    class period_scoreboard;
        logic          act_on_rising = 1'b1;
        logic          act_on_falling = 1'b0;
        logic          difference_mode = 1'b0;
        logic [15:0]   upper_count = '0;
        logic [31:0]   rise_stamp = '0;
        logic [31:0]   fall_stamp = '0;
        logic          expect_falling = 1'b0;
        logic [31:0]   ring_value [RING_SLOTS];
        logic [1:0]    ring_level [RING_SLOTS];
        logic [3:0]    wr_ptr = '0;
        logic [3:0]    rd_ptr = '0;
        logic [1:0]    held_level = '0;
        meter_result_t pending_q [$];
        int unsigned   mismatch_count = 0;

        function void write_reg(logic [1:0] idx, logic bit_value);
            case (idx)
                REG_ACT_ON_RISING:   act_on_rising = bit_value;
                REG_ACT_ON_FALLING:  act_on_falling = bit_value;
                REG_DIFFERENCE_MODE: difference_mode = bit_value;
                default: ;
            endcase
        endfunction

        // Advances the meter by one accepted input beat and queues its result.
        function void note_beat(logic opcode, logic overflowed, logic captured,
                                logic [15:0] cap);
            meter_result_t r;
            logic [15:0]   upper;
            logic [31:0]   stamp;
            logic [31:0]   period;
            logic [1:0]    lvl;
            r.value = '0;
            if (opcode == OP_EVENT) begin
                if (overflowed) upper_count = upper_count + 16'd1;
                if (captured) begin
                    expect_falling = !expect_falling;
                    upper = upper_count;
                    // A late capture in an overflow event belongs before the wrap.
                    if (overflowed && cap > LATE_CAPTURE_LIMIT) upper = upper - 16'd1;
                    stamp = {upper, cap};
                    period = '0;
                    if (expect_falling) begin
                        if (act_on_rising)
                            period = stamp - (difference_mode ? fall_stamp : rise_stamp);
                        rise_stamp = stamp;
                        lvl = difference_mode ? LVL_SPACE : LVL_MARK_SPACE;
                    end else begin
                        if (act_on_falling)
                            period = stamp - (difference_mode ? rise_stamp : fall_stamp);
                        fall_stamp = stamp;
                        lvl = difference_mode ? LVL_MARK : LVL_SPACE_MARK;
                    end
                    // Zero periods are dropped, and so is anything hitting a full ring.
                    if (period != 0 && wr_ptr + 4'd1 != rd_ptr) begin
                        wr_ptr = wr_ptr + 4'd1;
                        ring_value[wr_ptr] = period;
                        ring_level[wr_ptr] = lvl;
                    end
                end
            end else if (wr_ptr == rd_ptr) begin
                r.value = EMPTY_VALUE;
            end else begin
                rd_ptr = rd_ptr + 4'd1;
                r.value = ring_value[rd_ptr];
                held_level = ring_level[rd_ptr];
            end
            r.level = held_level;
            r.fill = wr_ptr - rd_ptr;
            pending_q.push_back(r);
        endfunction

        task report(string msg);
            $display("%0t mismatch: %s", $realtime, msg);
            mismatch_count++;
        endtask

        task check_beat(logic [31:0] value, logic [1:0] level, logic [3:0] fill);
            meter_result_t e;
            if (pending_q.size() == 0) begin
                report($sformatf("unexpected output beat value=%h", value));
            end else begin
                e = pending_q.pop_front();
                if (value !== e.value)
                    report($sformatf("read_value got %h want %h", value, e.value));
                if (level !== e.level)
                    report($sformatf("read_level got %0d want %0d", level, e.level));
                if (fill !== e.fill)
                    report($sformatf("fill_count got %0d want %0d", fill, e.fill));
            end
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;  // [0] overflowed, [1] captured, [17:2] capture_value
    logic        s_tuser = 1'b0;  // [0] opcode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;  // [31:0] read_value, [33:32] read_level, [37:34] fill_count

    period_scoreboard meter_sb = new();
    logic        steady = 1'b0;
    int unsigned stall_left = 0;
    int unsigned quiet_cycles = 0;
    logic [15:0] prev_cap = '0;
    logic [15:0] prev2_cap = '0;

    edge_capture_period_meter_unit #(.RING_DEPTH(RING_SLOTS)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #2 aclk = ~aclk;

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned idle_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Output side: random stalls unless a steady stretch is running.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (!steady && $urandom_range(0, 99) < 30) begin
            m_tready <= 1'b0;
            stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                     : $urandom_range(8, 40);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Every accepted output beat is checked against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            meter_sb.check_beat(m_tdata[31:0], m_tdata[33:32], m_tdata[37:34]);
    end

    // Watchdog on cycles with no beat moving on any port.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Writes one register through a setup phase and an access phase.
    task automatic apb_write(logic [1:0] idx, logic bit_value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {31'd0, bit_value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        meter_sb.write_reg(idx, bit_value);
    endtask

    // Offers one input beat and returns at the edge that accepts it.
    task automatic send_beat(logic opcode, logic overflowed, logic captured,
                             logic [15:0] cap);
        int unsigned gap;
        gap = steady ? 0 : idle_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= opcode;
        s_tdata <= {6'd0, cap, captured, overflowed};
        do @(posedge aclk); while (!s_tready);
        meter_sb.note_beat(opcode, overflowed, captured, cap);
        if (opcode == OP_EVENT && captured) begin
            prev2_cap = prev_cap;
            prev_cap = cap;
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (meter_sb.pending_q.size() != 0) @(posedge aclk);
    endtask

    initial begin
        logic [2:0]  mode;
        int unsigned read_pct;
        int unsigned kind;
        logic        opcode;
        logic        ov;
        logic        cp;
        logic [15:0] cap;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty read, late-capture boundary, zero period, extremes.
        send_beat(OP_READ, 1'b1, 1'b1, 16'hFFFF);
        send_beat(OP_EVENT, 1'b1, 1'b0, 16'h1234);
        send_beat(OP_EVENT, 1'b0, 1'b1, 16'h0010);
        send_beat(OP_EVENT, 1'b0, 1'b1, 16'h0100);
        send_beat(OP_EVENT, 1'b1, 1'b1, 16'hFFFF);
        send_beat(OP_EVENT, 1'b0, 1'b1, 16'h0005);
        send_beat(OP_EVENT, 1'b1, 1'b1, LATE_CAPTURE_LIMIT);
        send_beat(OP_EVENT, 1'b0, 1'b1, 16'hE001);
        send_beat(OP_EVENT, 1'b1, 1'b1, 16'hE001);
        send_beat(OP_EVENT, 1'b0, 1'b1, 16'h0000);
        send_beat(OP_EVENT, 1'b0, 1'b1, 16'hE001);
        send_beat(OP_EVENT, 1'b0, 1'b1, 16'h1111);
        send_beat(OP_EVENT, 1'b0, 1'b1, 16'hE001);
        repeat (6) send_beat(OP_READ, 1'b0, 1'b0, 16'h0000);
        drain();

        // A run of overflow events back to back, then a late capture across one.
        apb_write(REG_ACT_ON_FALLING, 1'b1);
        steady = 1'b1;
        repeat (40) send_beat(OP_EVENT, 1'b1, 1'b0, 16'($urandom));
        send_beat(OP_EVENT, 1'b1, 1'b1, 16'hF000);
        send_beat(OP_EVENT, 1'b0, 1'b1, 16'h0100);
        send_beat(OP_EVENT, 1'b0, 1'b1, 16'h0200);
        repeat (4) send_beat(OP_READ, 1'b1, 1'b0, 16'hAAAA);
        steady = 1'b0;
        drain();

        // Random phases: all eight modes first, then random ones.
        for (int phase = 0; phase < 12; phase++) begin
            mode = (phase < 8) ? 3'(phase) : 3'($urandom);
            apb_write(REG_ACT_ON_RISING, mode[0]);
            apb_write(REG_ACT_ON_FALLING, mode[1]);
            apb_write(REG_DIFFERENCE_MODE, mode[2]);
            case ($urandom_range(0, 3))
                0: read_pct = 5;
                1: read_pct = 30;
                2: read_pct = 50;
                default: read_pct = 80;
            endcase
            steady = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < 140; n++) begin
                opcode = ($urandom_range(0, 99) < read_pct) ? OP_READ : OP_EVENT;
                ov = ($urandom_range(0, 99) < 15);
                cp = ($urandom_range(0, 99) < 75);
                kind = $urandom_range(0, 99);
                if (kind < 40) begin
                    // Steady count forward; a wrap of the counter flags overflow.
                    cap = prev_cap + 16'($urandom_range(1, 3000));
                    if (cap < prev_cap) ov = 1'b1;
                end else if (kind < 55) begin
                    cap = prev2_cap;
                    ov = 1'b0;
                end else if (kind < 75) begin
                    case ($urandom_range(0, 5))
                        0: cap = 16'h0000;
                        1: cap = 16'hFFFF;
                        2: cap = LATE_CAPTURE_LIMIT;
                        3: cap = LATE_CAPTURE_LIMIT + 16'd1;
                        4: cap = LATE_CAPTURE_LIMIT - 16'd1;
                        default: cap = 16'h8000;
                    endcase
                end else begin
                    cap = 16'($urandom);
                end
                send_beat(opcode, ov, cp, cap);
            end
            steady = 1'b0;
            drain();
        end

        repeat (8) @(posedge aclk);
        if (meter_sb.mismatch_count == 0 && meter_sb.pending_q.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end
endmodule
